FILE: design/image_frame_deframer_macros.svh
// Assertion macros for the deframer top level.
`ifndef IMAGE_FRAME_DEFRAMER_MACROS_SVH
`define IMAGE_FRAME_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("image_frame_deframer: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("image_frame_deframer: assertion failed");

`endif

FILE: design/ifd_pkg.sv
package ifd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned WordW = 32;
	localparam int unsigned AsmW = 24;
	localparam int unsigned OutDataW = 168;

	typedef enum logic [2:0] {
		STAGE_LENGTH  = 3'd0,
		STAGE_PAYLOAD = 3'd1,
		STAGE_WIDTH   = 3'd2,
		STAGE_HEIGHT  = 3'd3,
		STAGE_FORMAT  = 3'd4
	} stage_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_FRAME   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [ByteW-1:0]   pl_byte;
		logic [WordW-1:0]   pl_index;
		logic               pl_last;
		logic [WordW-1:0]   frm_length;
		logic [WordW-1:0]   frm_width;
		logic [WordW-1:0]   frm_height;
		logic [WordW-1:0]   frm_format;
	} res_t;

endpackage

FILE: design/image_frame_deframer.sv
// The deframer takes one byte per transfer, a byte in every cycle while not stalled.
// Each frame is a 32-bit big-endian payload length, the payload bytes, and then
// 32-bit big-endian width, height and format words. Every payload byte leaves
// as a transfer with tuser low, its index in tdata and tlast high on the final
// one; the last format byte yields one transfer with tuser high that carries
// length, width, height and format. Header bytes other than the last format
// byte yield nothing. A result appears in the cycle after its byte is taken, from
// a single output register, and a new byte is taken whenever that register is
// empty or is being emptied in the same cycle.
`include "image_frame_deframer_macros.svh"

module image_frame_deframer
	import ifd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ByteW-1:0]    s_tdata,   // data_byte[7:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // payload_byte[7:0], payload_index[39:8],
	                                       // frame_length[71:40], frame_width[103:72],
	                                       // frame_height[135:104], frame_format[167:136]
	output logic                m_tlast,   // payload_last
	output logic                m_tuser    // result_kind
);

	logic   take;
	logic   res_valid;
	res_t   res;
	stage_t stage;
	logic   out_valid_q;
	res_t   out_q;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	ifd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (s_tdata),
		.stage     (stage),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.frm_format, out_q.frm_height, out_q.frm_width,
	                   out_q.frm_length, out_q.pl_index, out_q.pl_byte};
	assign m_tlast  = out_q.pl_last;
	assign m_tuser  = out_q.kind;

	`IFD_ASSERT_SAME(a_ready_when_empty, !out_valid_q, s_tready)
	`IFD_ASSERT_NEXT(a_payload_gives_result, take && (stage == STAGE_PAYLOAD),
		m_tvalid && (m_tuser == KIND_PAYLOAD))
	`IFD_ASSERT_SAME(a_frame_has_no_last, m_tvalid && (m_tuser == KIND_FRAME), !m_tlast)

endmodule

FILE: design/ifd_parse.sv
module ifd_parse
	import ifd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [ByteW-1:0] data_byte,
	output stage_t           stage,
	output logic             res_valid,
	output res_t             res
);

	stage_t             stage_q, stage_d;
	logic [WordW-1:0]   pos_q, pos_d;
	logic [AsmW-1:0]    asm_q, asm_d;
	logic [WordW-1:0]   len_q, len_d;
	logic [WordW-1:0]   wid_q, wid_d;
	logic [WordW-1:0]   hgt_q, hgt_d;
	logic [WordW-1:0]   pos_inc;
	logic [WordW-1:0]   word;
	logic               hdr_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= STAGE_LENGTH;
			pos_q   <= '0;
			asm_q   <= '0;
			len_q   <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
		end else if (take) begin
			stage_q <= stage_d;
			pos_q   <= pos_d;
			asm_q   <= asm_d;
			len_q   <= len_d;
			wid_q   <= wid_d;
			hgt_q   <= hgt_d;
		end
	end

	assign pos_inc  = pos_q + WordW'(1);
	assign word     = {asm_q, data_byte};
	assign hdr_done = (pos_q >= WordW'(3));

	always_comb begin
		stage_d   = stage_q;
		pos_d     = pos_q;
		asm_d     = asm_q;
		len_d     = len_q;
		wid_d     = wid_q;
		hgt_d     = hgt_q;
		res_valid = 1'b0;
		res       = '0;

		// Header fields collect four bytes, most significant first.
		if (stage_q != STAGE_PAYLOAD) begin
			if (hdr_done) begin
				asm_d = '0;
				pos_d = '0;
			end else begin
				asm_d = {asm_q[AsmW-ByteW-1:0], data_byte};
				pos_d = pos_inc;
			end
		end

		unique case (stage_q)
			STAGE_PAYLOAD: begin
				res_valid    = 1'b1;
				res.kind     = KIND_PAYLOAD;
				res.pl_byte  = data_byte;
				res.pl_index = pos_q;
				res.pl_last  = (pos_inc == len_q);
				if (pos_inc >= len_q) begin
					pos_d   = '0;
					stage_d = STAGE_WIDTH;
				end else begin
					pos_d = pos_inc;
				end
			end
			STAGE_WIDTH: begin
				if (hdr_done) begin
					wid_d   = word;
					stage_d = STAGE_HEIGHT;
				end
			end
			STAGE_HEIGHT: begin
				if (hdr_done) begin
					hgt_d   = word;
					stage_d = STAGE_FORMAT;
				end
			end
			STAGE_FORMAT: begin
				if (hdr_done) begin
					stage_d        = STAGE_LENGTH;
					res_valid      = 1'b1;
					res.kind       = KIND_FRAME;
					res.frm_length = len_q;
					res.frm_width  = wid_q;
					res.frm_height = hgt_q;
					res.frm_format = word;
				end
			end
			default: begin
				// The length stage; codes that cannot arise fall in here as well.
				stage_d = STAGE_LENGTH;
				if (hdr_done) begin
					len_d   = word;
					stage_d = (word == '0) ? STAGE_WIDTH : STAGE_PAYLOAD;
				end
			end
		endcase
	end

	assign stage = stage_q;

endmodule

FILE: dv/image_frame_deframer_test.sv
module image_frame_deframer_test;
	import ifd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ByteW-1:0] data;
		bit               typed;
		res_t             want;
	} plan_row_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [ByteW-1:0]    s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tlast;
	logic                m_tuser;

	stage_t           stage = STAGE_LENGTH;
	logic [WordW-1:0] byte_pos = '0;
	logic [AsmW-1:0]  word_bytes = '0;
	logic [WordW-1:0] frame_len = '0;
	logic [WordW-1:0] frame_wid = '0;
	logic [WordW-1:0] frame_hgt = '0;

	res_t results_due[$];
	bit   calm = 1'b0;
	int   stall_left = 0;
	int   errors = 0;
	int   bytes_sent = 0;
	int   frames_sent = 0;
	int   payload_seen = 0;
	int   frame_seen = 0;

	// A length of two with extreme payload bytes, then a frame with zero length.
	plan_row_t directed_plan [22] = '{
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 32'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{8'h00, 1'b1, '{KIND_PAYLOAD, 8'h00, 32'd1, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0}},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h80, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h01, 1'b1, '{KIND_FRAME, 8'h00, 32'd0, 1'b0, 32'd2, 32'hFFFF_FFFF, 32'd0,
		                 32'h8000_0001}},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0}
	};

	image_frame_deframer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL image_frame_deframer");
		$finish;
	end

	function automatic bit collect_word(input logic [ByteW-1:0] b, output logic [WordW-1:0] w);
		w = '0;
		if (byte_pos >= 3) begin
			w = {word_bytes, b};
			word_bytes = '0;
			byte_pos = '0;
			return 1'b1;
		end
		word_bytes = {word_bytes[AsmW-ByteW-1:0], b};
		byte_pos = byte_pos + 1;
		return 1'b0;
	endfunction

	function automatic bit parse_byte(input logic [ByteW-1:0] b, output res_t r);
		logic [WordW-1:0] w;
		r = '0;
		case (stage)
			STAGE_PAYLOAD: begin
				r.kind = KIND_PAYLOAD;
				r.pl_byte = b;
				r.pl_index = byte_pos;
				r.pl_last = (byte_pos + 32'd1 == frame_len);
				if (byte_pos + 32'd1 >= frame_len) begin
					byte_pos = '0;
					stage = STAGE_WIDTH;
				end else begin
					byte_pos = byte_pos + 1;
				end
				return 1'b1;
			end
			STAGE_WIDTH: begin
				if (collect_word(b, w)) begin
					frame_wid = w;
					stage = STAGE_HEIGHT;
				end
				return 1'b0;
			end
			STAGE_HEIGHT: begin
				if (collect_word(b, w)) begin
					frame_hgt = w;
					stage = STAGE_FORMAT;
				end
				return 1'b0;
			end
			STAGE_FORMAT: begin
				if (collect_word(b, w)) begin
					stage = STAGE_LENGTH;
					r.kind = KIND_FRAME;
					r.frm_length = frame_len;
					r.frm_width = frame_wid;
					r.frm_height = frame_hgt;
					r.frm_format = w;
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				stage = STAGE_LENGTH;
				if (collect_word(b, w)) begin
					frame_len = w;
					stage = (w == '0) ? STAGE_WIDTH : STAGE_PAYLOAD;
				end
				return 1'b0;
			end
		endcase
	endfunction

	task automatic push_byte(input logic [ByteW-1:0] b, input bit typed, input res_t want);
		int unsigned gap;
		res_t r;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 3);
		repeat (gap) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		if (parse_byte(b, r))
			results_due.push_back(typed ? want : r);
		bytes_sent++;
	endtask

	task automatic send_word(input logic [WordW-1:0] w);
		for (int i = 3; i >= 0; i--)
			push_byte(w[8*i +: 8], 1'b0, '0);
	endtask

	function automatic logic [WordW-1:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 4095);
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [WordW-1:0] pick_length();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 32'd1;
			2, 3: return $urandom_range(2, 4);
			4, 5, 6, 7: return $urandom_range(5, 16);
			8: return $urandom_range(17, 64);
			default: return $urandom_range(65, 300);
		endcase
	endfunction

	task automatic send_frame();
		logic [WordW-1:0] len;
		len = pick_length();
		calm = ($urandom_range(0, 4) == 0);
		send_word(len);
		for (int unsigned i = 0; i < len; i++)
			push_byte(ByteW'($urandom_range(0, 255)), 1'b0, '0);
		send_word(pick_word());
		send_word(pick_word());
		send_word(pick_word());
		frames_sent++;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = kind_t'(m_tuser);
			got.pl_byte = m_tdata[7:0];
			got.pl_index = m_tdata[39:8];
			got.pl_last = m_tlast;
			got.frm_length = m_tdata[71:40];
			got.frm_width = m_tdata[103:72];
			got.frm_height = m_tdata[135:104];
			got.frm_format = m_tdata[167:136];
			if (got.kind == KIND_FRAME)
				frame_seen++;
			else
				payload_seen++;
			if (results_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transfer: kind %0d tdata %h tlast %b",
						m_tuser, m_tdata, m_tlast);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch exp/got: kind %0d/%0d byte %h/%h index %h/%h last %b/%b",
							want.kind, got.kind, want.pl_byte, got.pl_byte,
							want.pl_index, got.pl_index, want.pl_last, got.pl_last);
						$display("  length %h/%h width %h/%h height %h/%h format %h/%h",
							want.frm_length, got.frm_length, want.frm_width, got.frm_width,
							want.frm_height, got.frm_height, want.frm_format, got.frm_format);
					end
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i])
			push_byte(directed_plan[i].data, directed_plan[i].typed, directed_plan[i].want);

		// The directed part leaves the parser after a zero length word.
		send_word(pick_word());
		send_word(pick_word());
		send_word(pick_word());
		frames_sent += 2;

		while (bytes_sent < 1780)
			send_frame();

		// Largest length last, since the parser stays in its payload for the rest of the test.
		calm = 1'b1;
		send_word('1);
		repeat (24)
			push_byte(ByteW'($urandom_range(0, 255)), 1'b0, '0);
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes in %0d frames plus an open frame of maximum length.",
			bytes_sent, frames_sent);
		$display("Checked %0d payload transfers and %0d frame transfers, %0d errors.",
			payload_seen, frame_seen, errors);
		if (errors == 0)
			$display("PASS image_frame_deframer");
		else
			$display("FAIL image_frame_deframer");
		$finish;
	end

endmodule
